// ===== sv/soundex_encoder_macros.svh =====
// Assertion helpers for the soundex encoder.
// Each use expects the module to have clock and reset signals in scope.
`ifndef SOUNDEX_ENCODER_MACROS_SVH
`define SOUNDEX_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SDX_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SDX_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (conseq)) else $error(msg);

`endif

// ===== sv/sdx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdx_pkg;

   typedef logic [7:0] char_type;
   typedef logic [2:0] class_type;
   typedef logic [1:0] count_type;
   typedef logic [5:0] digit_type;

   localparam class_type CLASS_NONE = 3'd0;
   localparam class_type CLASS_LABIAL = 3'd1;
   localparam class_type CLASS_GUTTURAL = 3'd2;
   localparam class_type CLASS_DENTAL = 3'd3;
   localparam class_type CLASS_LATERAL = 3'd4;
   localparam class_type CLASS_NASAL = 3'd5;
   localparam class_type CLASS_RHOTIC = 3'd6;

   localparam count_type CODE_DIGITS_FULL = 2'd3;

   // Upper bits of ASCII '0'; the class fills the low three bits.
   localparam logic [2:0] ASCII_DIGIT_HIGH = 3'b110;

   function automatic class_type class_of(input char_type ch);
      class_type cls;
      begin
         case (ch) inside
            "b", "f", "p", "v": cls = CLASS_LABIAL;
            "c", "g", "j", "k", "q", "s", "x", "z": cls = CLASS_GUTTURAL;
            "d", "t": cls = CLASS_DENTAL;
            "l": cls = CLASS_LATERAL;
            "m", "n": cls = CLASS_NASAL;
            "r": cls = CLASS_RHOTIC;
            default: cls = CLASS_NONE;
         endcase
         class_of = cls;
      end
   endfunction

   function automatic digit_type to_ascii(input class_type cls);
      to_ascii = {ASCII_DIGIT_HIGH, cls};
   endfunction

endpackage

`default_nettype wire

// ===== sv/soundex_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Soundex encoder: one character per transaction on the req_ channel, word_end
// set on the last character of a word. One code comes out on the rsp_ channel
// per word: the first character unchanged, then three ASCII digits '0'..'6'
// (padded with '0' when fewer than three classes were found).
// Pipeline: an input register, then the per-character class lookup and
// compare, then the result register. A word's code is loaded into the result
// register as its last character leaves the input register; that character
// waits there while a code is stalled. rsp_valid rises with the load.
// Throughput: one character per cycle while no word_end waits; the class
// lookup and word state update fit in the single stage between the registers.
// Reset (synchronous, active high) empties both registers and readies the
// block for the first character of a new word.
// When rsp_stall holds a code, characters without word_end keep flowing; a
// word_end character waits in the input register and req_stall rises once
// that register is occupied and cannot advance.
// Both sides follow valid/stall: a transaction moves on a rising edge with
// valid high and stall low.
module soundex_encoder (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire sdx_pkg::char_type  req_letter,
   input  wire                 req_word_end,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output sdx_pkg::char_type   rsp_first_char,
   output sdx_pkg::digit_type  rsp_digit_one,
   output sdx_pkg::digit_type  rsp_digit_two,
   output sdx_pkg::digit_type  rsp_digit_three
);
   import sdx_pkg::*;

   // input register
   logic      s1_valid_ff, s1_valid_in;
   char_type  s1_letter_ff;
   logic      s1_word_end_ff;
   logic      s1_advance;
   logic      req_take;

   // word state
   logic      awaiting_first_ff, awaiting_first_in;
   char_type  held_first_ff, held_first_in;
   class_type prev_class_ff, prev_class_in;
   count_type digit_count_ff, digit_count_in;
   class_type digits_ff [3];
   class_type digits_in [3];
   class_type cur_class;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   char_type  rsp_first_ff;
   digit_type rsp_one_ff, rsp_two_ff, rsp_three_ff;
   logic      rsp_load;

   // A word_end character needs the result slot free; others always advance.
   assign s1_advance = s1_valid_ff && (!s1_word_end_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;
   assign rsp_load   = s1_advance && s1_word_end_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_advance;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_letter_ff   <= req_letter;
         s1_word_end_ff <= req_word_end;
      end
   end

   assign cur_class = class_of(s1_letter_ff);

   always_comb begin
      awaiting_first_in = awaiting_first_ff;
      held_first_in     = held_first_ff;
      prev_class_in     = prev_class_ff;
      digit_count_in    = digit_count_ff;
      digits_in         = digits_ff;
      if (awaiting_first_ff) begin
         held_first_in     = s1_letter_ff;
         awaiting_first_in = 1'b0;
         prev_class_in     = CLASS_NONE;
         digit_count_in    = '0;
         digits_in[0]      = CLASS_NONE;
         digits_in[1]      = CLASS_NONE;
         digits_in[2]      = CLASS_NONE;
      end else if (digit_count_ff != CODE_DIGITS_FULL && cur_class != CLASS_NONE) begin
         if (cur_class != prev_class_ff) begin
            digits_in[digit_count_ff] = cur_class;
            digit_count_in            = digit_count_ff + 2'd1;
         end
         prev_class_in = cur_class;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || rsp_load) begin
         // drop the word state once its code is out
         awaiting_first_ff <= 1'b1;
         held_first_ff     <= '0;
         prev_class_ff     <= CLASS_NONE;
         digit_count_ff    <= '0;
         digits_ff[0]      <= CLASS_NONE;
         digits_ff[1]      <= CLASS_NONE;
         digits_ff[2]      <= CLASS_NONE;
      end else if (s1_advance) begin
         awaiting_first_ff <= awaiting_first_in;
         held_first_ff     <= held_first_in;
         prev_class_ff     <= prev_class_in;
         digit_count_ff    <= digit_count_in;
         digits_ff         <= digits_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_first_ff <= held_first_in;
         rsp_one_ff   <= to_ascii(digits_in[0]);
         rsp_two_ff   <= to_ascii(digits_in[1]);
         rsp_three_ff <= to_ascii(digits_in[2]);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_char  = rsp_first_ff;
   assign rsp_digit_one   = rsp_one_ff;
   assign rsp_digit_two   = rsp_two_ff;
   assign rsp_digit_three = rsp_three_ff;

`include "soundex_encoder_macros.svh"

   `SDX_ASSERT_NOW(a_fresh_word_clear, awaiting_first_ff,
      (digit_count_ff == 2'd0) && (prev_class_ff == CLASS_NONE),
      "word state not clear while awaiting first character")
   `SDX_ASSERT_NOW(a_unused_digits_zero, digit_count_ff == 2'd0,
      (digits_ff[0] == CLASS_NONE) && (digits_ff[1] == CLASS_NONE) &&
      (digits_ff[2] == CLASS_NONE),
      "digit held beyond count")
   `SDX_ASSERT_NEXT(a_word_end_emits, rsp_load, rsp_valid_ff && awaiting_first_ff,
      "word end did not produce a code and restart")
   `SDX_ASSERT_NOW(a_stall_reason, req_stall,
      s1_valid_ff && s1_word_end_ff && rsp_valid_ff && rsp_stall,
      "input stalled without a blocked word end")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import sdx_pkg::*;

   typedef struct packed {
      char_type  first_char;
      digit_type digit_one;
      digit_type digit_two;
      digit_type digit_three;
   } soundex_code_type;

   localparam digit_type DIGIT_ZERO = 6'd48;
   localparam int REPORT_LIMIT = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PERCENT = 21;

   // Tracks the word in flight and the codes still owed by the block.
   class soundex_code_tracker;
      bit               awaiting_first;
      char_type         first_char;
      class_type        last_group;
      count_type        digit_count;
      class_type        group_digits [3];
      soundex_code_type pending_codes [$];
      int               mismatches;
      int               faults;

      function new();
         clear_word();
         mismatches = 0;
         faults = 0;
      endfunction

      function void clear_word();
         awaiting_first = 1'b1;
         first_char = '0;
         last_group = CLASS_NONE;
         digit_count = '0;
         group_digits = '{CLASS_NONE, CLASS_NONE, CLASS_NONE};
      endfunction

      function class_type sound_group(input char_type ch);
         case (ch)
            "b", "f", "p", "v": return CLASS_LABIAL;
            "c", "g", "j", "k", "q", "s", "x", "z": return CLASS_GUTTURAL;
            "d", "t": return CLASS_DENTAL;
            "l": return CLASS_LATERAL;
            "m", "n": return CLASS_NASAL;
            "r": return CLASS_RHOTIC;
            default: return CLASS_NONE;
         endcase
      endfunction

      function void take_char(input char_type ch, input bit last);
         class_type        grp;
         soundex_code_type code;
         if (awaiting_first) begin
            clear_word();
            awaiting_first = 1'b0;
            first_char = ch;
         end else if (digit_count != CODE_DIGITS_FULL) begin
            grp = sound_group(ch);
            // vowels and the like leave the previous group in place
            if (grp != CLASS_NONE) begin
               if (grp != last_group) begin
                  group_digits[digit_count] = grp;
                  digit_count = digit_count + 2'd1;
               end
               last_group = grp;
            end
         end
         if (last) begin
            code.first_char = first_char;
            code.digit_one = DIGIT_ZERO + digit_type'(group_digits[0]);
            code.digit_two = DIGIT_ZERO + digit_type'(group_digits[1]);
            code.digit_three = DIGIT_ZERO + digit_type'(group_digits[2]);
            pending_codes.push_back(code);
            clear_word();
         end
      endfunction

      function void compare_code(input soundex_code_type seen);
         soundex_code_type want;
         if (pending_codes.size() == 0) begin
            faults++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected code: first=%h digits=%h %h %h", seen.first_char,
                        seen.digit_one, seen.digit_two, seen.digit_three);
            return;
         end
         want = pending_codes.pop_front();
         if (seen !== want) begin
            faults++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("code mismatch: expected %h %h %h %h, got %h %h %h %h",
                        want.first_char, want.digit_one, want.digit_two, want.digit_three,
                        seen.first_char, seen.digit_one, seen.digit_two, seen.digit_three);
         end
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   wire       req_stall;
   char_type  req_letter = '0;
   logic      req_word_end = 1'b0;
   wire       rsp_valid;
   logic      rsp_stall = 1'b0;
   char_type  rsp_first_char;
   digit_type rsp_digit_one;
   digit_type rsp_digit_two;
   digit_type rsp_digit_three;

   soundex_code_tracker tracker = new();
   bit no_idle = 1'b0;
   int cycle_count = 0;

   soundex_encoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_letter(req_letter),
      .req_word_end(req_word_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_first_char(rsp_first_char),
      .rsp_digit_one(rsp_digit_one),
      .rsp_digit_two(rsp_digit_two),
      .rsp_digit_three(rsp_digit_three)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[soundex_encoder] ERROR");
         $finish;
      end
   end

   // Result side: sample the pre-edge handshake, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.compare_code({rsp_first_char, rsp_digit_one, rsp_digit_two, rsp_digit_three});
      rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
   end

   task automatic send_char(input char_type ch, input bit last);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_letter <= ch;
      req_word_end <= last;
      // hold the transaction until the block takes it
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.take_char(ch, last);
   endtask

   task automatic send_word(input string text);
      int i;
      for (i = 0; i < text.len(); i++)
         send_char(text[i], i == text.len() - 1);
   endtask

   initial begin
      int       sent;
      int       word_len;
      int       pick;
      int       k;
      bit       noisy;
      bit       last;
      char_type ch;

      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_char("a", 1'b1);
      send_char(8'hff, 1'b1);
      send_char(8'h00, 1'b1);
      send_word("robert");
      send_word("pfister");
      send_word("bmhn");
      send_word("XlM");

      while (sent < 1500) begin
         no_idle = (sent >= 500 && sent < 800);
         noisy = ($urandom_range(9) == 0);
         word_len = ($urandom_range(7) == 0) ? $urandom_range(20, 1) : $urandom_range(8, 1);
         for (k = 0; k < word_len; k++) begin
            pick = $urandom_range(99);
            if (noisy || pick >= 90)
               ch = char_type'($urandom_range(255));
            else if (pick < 75)
               ch = "a" + char_type'($urandom_range(25));
            else
               ch = "A" + char_type'($urandom_range(25));
            last = (k == word_len - 1);
            sent++;
            send_char(ch, last);
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (tracker.pending_codes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (tracker.faults == 0 && tracker.pending_codes.size() == 0)
         $display("[soundex_encoder] OK");
      else
         $display("[soundex_encoder] ERROR");
      $finish;
   end

endmodule
